@@ design/ptic_pkg.sv @@
// Shared constants and types for the pulse train interval checker.
// No dependencies; used by ptic_debounce, pulse_train_interval_checker and the testbench.
package ptic_pkg;

    // Default parameter values
    localparam int FilterLen    = 5;
    localparam int SilenceTicks = 500;
    localparam int SlotCount    = 3;

    // Fixed widths from the interface and state
    localparam int FILT_W    = 3;
    localparam int TIMER_W   = 10;
    localparam int BOUND_W   = 8;
    localparam int SLOT_W    = 2;
    localparam int VERDICT_W = 2;
    localparam int STORE_DEPTH = 3;

    localparam logic [TIMER_W-1:0] TIMER_MAX = 10'd1023;

    // Register reset values
    localparam logic [BOUND_W-1:0] MIN_RESET = 8'd10;
    localparam logic [BOUND_W-1:0] MAX_RESET = 8'd30;

    // Configuration register indexes
    localparam logic CFG_MIN = 1'b0;
    localparam logic CFG_MAX = 1'b1;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_REFUSE = 2'd2;

    // Filter status handed from the debouncer to the timing logic
    typedef struct packed {
        logic level_next;
        logic level_edge;
    } filt_stat_t;

endpackage

@@ design/ptic_debounce.sv @@
// Up/down integrating debouncer: turns raw pin beats into a filtered level.
// Depends on ptic_pkg.
module ptic_debounce #(
    parameter int FILTER_LEN = ptic_pkg::FilterLen
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                pin,
    output logic                level,
    output ptic_pkg::filt_stat_t stat
);

    localparam logic [ptic_pkg::FILT_W-1:0] LIMIT = ptic_pkg::FILT_W'(FILTER_LEN);

    logic [ptic_pkg::FILT_W-1:0] count_reg, count_next;
    logic                        level_reg, level_next;

    // Integrate towards the pin; switch level only at the rails
    always_comb begin
        count_next = count_reg;
        level_next = level_reg;
        if (pin && (count_reg < LIMIT)) begin
            count_next = count_reg + 1'b1;
            if (count_next == LIMIT) begin
                level_next = 1'b1;
            end
        end else if (!pin && (count_reg != '0)) begin
            count_next = count_reg - 1'b1;
            if (count_next == '0) begin
                level_next = 1'b0;
            end
        end
    end

    // Advance once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            level_reg <= 1'b0;
        end else if (step) begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

    assign level           = level_reg;
    assign stat.level_next = level_next;
    assign stat.level_edge = level_next ^ level_reg;

endmodule

@@ design/pulse_train_interval_checker.sv @@
// Top level of the pulse train interval checker: interval timing, train judge, watchdog.
// Depends on ptic_pkg and ptic_debounce.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+---------------------------------------------
//  s_       | in        | s_valid / s_ready   | s_pin_level
//  m_       | out       | m_valid / m_ready   | m_verdict, m_interval_first/second/third,
//           |           |                     | m_debounced_level
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index (0 min, 1 max), cfg_data
//
// One pin beat is taken per cycle while s_ready is high; its result is registered on acceptance.
// Timing, train and watchdog state advance only on an accepted beat, through one level of counters and compares.
// s_ready is high while the output register is empty or being drained, so a stalled m_ready
// holds the result and keeps s_ready low until it is taken. Reset is synchronous, active low,
// and returns all counters, buffers and bounds to their defaults; cfg_ready is always high.
module pulse_train_interval_checker #(
    parameter int FILTER_LEN    = ptic_pkg::FilterLen,
    parameter int SILENCE_TICKS = ptic_pkg::SilenceTicks,
    parameter int SLOT_COUNT    = ptic_pkg::SlotCount
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_pin_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ptic_pkg::VERDICT_W-1:0]      m_verdict,
    output logic [ptic_pkg::TIMER_W-1:0]        m_interval_first,
    output logic [ptic_pkg::TIMER_W-1:0]        m_interval_second,
    output logic [ptic_pkg::TIMER_W-1:0]        m_interval_third,
    output logic                                m_debounced_level,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [ptic_pkg::BOUND_W-1:0]        cfg_data
);

    localparam int SIL_W = $clog2(SILENCE_TICKS + 2);
    localparam logic [SIL_W-1:0]            SIL_LIMIT = SIL_W'(SILENCE_TICKS);
    localparam logic [ptic_pkg::SLOT_W-1:0] SLOT_FULL = ptic_pkg::SLOT_W'(SLOT_COUNT);

    typedef logic [ptic_pkg::TIMER_W-1:0] ival_t;

    logic accept;
    logic filt_level;
    ptic_pkg::filt_stat_t filt_stat;

    logic [ptic_pkg::BOUND_W-1:0] min_reg, max_reg;
    ival_t                        timer_reg, timer_next;
    ival_t                        store_reg [ptic_pkg::STORE_DEPTH];
    ival_t                        store_next [ptic_pkg::STORE_DEPTH];
    ival_t                        capture_reg [ptic_pkg::STORE_DEPTH];
    ival_t                        capture_next [ptic_pkg::STORE_DEPTH];
    logic [ptic_pkg::SLOT_W-1:0]  slot_reg, slot_next, slot_idx;
    logic                         armed_reg, armed_next;
    logic [SIL_W-1:0]             silence_reg, silence_next, silence_inc;
    logic [ptic_pkg::VERDICT_W-1:0] verdict_reg, verdict_next;
    logic                         m_valid_reg;
    logic                         train_ok, train_full;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    ptic_debounce #(
        .FILTER_LEN (FILTER_LEN)
    ) u_debounce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .pin     (s_pin_level),
        .level   (filt_level),
        .stat    (filt_stat)
    );

    // Next state for one beat: store on edge, judge a full train, run the watchdog
    always_comb begin
        timer_next   = timer_reg;
        slot_next    = slot_reg;
        armed_next   = armed_reg;
        silence_next = silence_reg;
        verdict_next = ptic_pkg::VERDICT_NONE;
        train_ok     = 1'b1;
        slot_idx     = (slot_reg >= SLOT_FULL) ? '0 : slot_reg;
        for (int k = 0; k < ptic_pkg::STORE_DEPTH; k++) begin
            store_next[k]   = store_reg[k];
            capture_next[k] = capture_reg[k];
        end

        // Edge of the filtered level: restart after silence, else store the interval
        if (filt_stat.level_edge) begin
            silence_next = '0;
            timer_next   = '0;
            if (armed_reg) begin
                armed_next = 1'b0;
                slot_next  = '0;
            end else begin
                store_next[slot_idx] = timer_reg;
                slot_next            = slot_idx + 1'b1;
            end
        end

        // Full train: check each interval and copy out
        train_full = (slot_next == SLOT_FULL);
        if (train_full) begin
            for (int k = 0; k < ptic_pkg::STORE_DEPTH; k++) begin
                if (k < SLOT_COUNT) begin
                    if (!((store_next[k] > ival_t'(min_reg)) &&
                          (store_next[k] < ival_t'(max_reg)))) begin
                        train_ok = 1'b0;
                    end
                    capture_next[k] = store_next[k];
                end
            end
            verdict_next = train_ok ? ptic_pkg::VERDICT_ACCEPT : ptic_pkg::VERDICT_REFUSE;
            silence_next = SIL_LIMIT;
        end

        // Silence watchdog: clear the buffer and arm idle
        silence_inc = silence_next + 1'b1;
        silence_next = silence_inc;
        if (silence_inc > SIL_LIMIT) begin
            for (int k = 0; k < ptic_pkg::STORE_DEPTH; k++) begin
                store_next[k] = '0;
            end
            armed_next   = 1'b1;
            slot_next    = '0;
            silence_next = '0;
        end

        // Saturating interval timer
        if (timer_next < ptic_pkg::TIMER_MAX) begin
            timer_next = timer_next + 1'b1;
        end
    end

    // Hold state; advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg   <= '0;
            slot_reg    <= '0;
            armed_reg   <= 1'b0;
            silence_reg <= '0;
            verdict_reg <= ptic_pkg::VERDICT_NONE;
            for (int k = 0; k < ptic_pkg::STORE_DEPTH; k++) begin
                store_reg[k]   <= '0;
                capture_reg[k] <= '0;
            end
        end else if (accept) begin
            timer_reg   <= timer_next;
            slot_reg    <= slot_next;
            armed_reg   <= armed_next;
            silence_reg <= silence_next;
            verdict_reg <= verdict_next;
            for (int k = 0; k < ptic_pkg::STORE_DEPTH; k++) begin
                store_reg[k]   <= store_next[k];
                capture_reg[k] <= capture_next[k];
            end
        end
    end

    // Output beat valid: set on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= ptic_pkg::MIN_RESET;
            max_reg <= ptic_pkg::MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ptic_pkg::CFG_MIN: min_reg <= cfg_data;
                ptic_pkg::CFG_MAX: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_verdict         = verdict_reg;
    assign m_interval_first  = capture_reg[0];
    assign m_interval_second = capture_reg[1];
    assign m_interval_third  = capture_reg[2];
    assign m_debounced_level = filt_level;

endmodule

@@ tb/ptic_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the pulse train interval checker: mirrors debounce, interval timing,
// train judge and silence watchdog, then compares every result beat with its prediction.
// Depends on ptic_pkg; sits beside the block in testbench and only watches its ports.
module ptic_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_pin_level,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [ptic_pkg::VERDICT_W-1:0] m_verdict,
    input  logic [ptic_pkg::TIMER_W-1:0]   m_interval_first,
    input  logic [ptic_pkg::TIMER_W-1:0]   m_interval_second,
    input  logic [ptic_pkg::TIMER_W-1:0]   m_interval_third,
    input  logic                           m_debounced_level,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [ptic_pkg::BOUND_W-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             trains_accepted,
    output int                             trains_refused
);
    import ptic_pkg::*;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [TIMER_W-1:0]   first;
        logic [TIMER_W-1:0]   second;
        logic [TIMER_W-1:0]   third;
        logic                 level;
    } tick_result_t;

    // Mirrored block state and bounds
    logic [FILT_W-1:0]  flt_cnt;
    logic               flt_lvl;
    logic               prev_lvl;
    logic [TIMER_W-1:0] ivl_timer;
    logic [TIMER_W-1:0] ivl_store [STORE_DEPTH];
    logic [SLOT_W-1:0]  slot;
    logic               idle_armed;
    logic [TIMER_W-1:0] quiet_cnt;
    logic [TIMER_W-1:0] capt [STORE_DEPTH];
    logic [BOUND_W-1:0] lo_bound;
    logic [BOUND_W-1:0] hi_bound;

    tick_result_t expected_ticks [$];
    int mismatch_total = 0;
    int accept_total   = 0;
    int refuse_total   = 0;

    // Advance the mirrored state by one pin sample and return the result it gives
    function automatic tick_result_t step_train_state(logic pin);
        tick_result_t r;
        logic         fits;
        r.verdict = VERDICT_NONE;

        // integrate towards the pin, switching level at either end of the range
        if (pin && flt_cnt < FilterLen) begin
            flt_cnt = flt_cnt + 1'b1;
            if (flt_cnt == FilterLen) flt_lvl = 1'b1;
        end else if (!pin && flt_cnt > 0) begin
            flt_cnt = flt_cnt - 1'b1;
            if (flt_cnt == 0) flt_lvl = 1'b0;
        end

        // filtered edge: restart after silence, otherwise store the interval
        if (prev_lvl != flt_lvl) begin
            quiet_cnt = '0;
            if (idle_armed) begin
                idle_armed = 1'b0;
                slot       = '0;
                ivl_timer  = '0;
            end else begin
                if (slot >= SlotCount) slot = '0;
                ivl_store[slot] = ivl_timer;
                slot            = slot + 1'b1;
                ivl_timer       = '0;
            end
        end
        prev_lvl = flt_lvl;

        // full train: judge against the open bounds and copy out
        if (slot == SlotCount) begin
            fits = 1'b1;
            for (int k = 0; k < SlotCount && k < STORE_DEPTH; k++) begin
                if (!(ivl_store[k] > lo_bound && ivl_store[k] < hi_bound)) fits = 1'b0;
                capt[k] = ivl_store[k];
            end
            r.verdict = fits ? VERDICT_ACCEPT : VERDICT_REFUSE;
            quiet_cnt = SilenceTicks;
        end

        // silence watchdog
        quiet_cnt = quiet_cnt + 1'b1;
        if (quiet_cnt > SilenceTicks) begin
            for (int k = 0; k < STORE_DEPTH; k++) ivl_store[k] = '0;
            idle_armed = 1'b1;
            slot       = '0;
            quiet_cnt  = '0;
        end

        if (ivl_timer < TIMER_MAX) ivl_timer = ivl_timer + 1'b1;

        r.first  = capt[0];
        r.second = capt[1];
        r.third  = capt[2];
        r.level  = flt_lvl;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin
        tick_result_t want;
        if (!aresetn) begin
            flt_cnt    = '0;
            flt_lvl    = 1'b0;
            prev_lvl   = 1'b0;
            ivl_timer  = '0;
            slot       = '0;
            idle_armed = 1'b0;
            quiet_cnt  = '0;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                ivl_store[k] = '0;
                capt[k]      = '0;
            end
            lo_bound = MIN_RESET;
            hi_bound = MAX_RESET;
            expected_ticks.delete();
        end else begin
            // bound writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN: lo_bound = cfg_data;
                    CFG_MAX: hi_bound = cfg_data;
                endcase
            end

            // predict each accepted pin beat
            if (s_valid && s_ready) begin
                want = step_train_state(s_pin_level);
                if (want.verdict == VERDICT_ACCEPT) accept_total++;
                if (want.verdict == VERDICT_REFUSE) refuse_total++;
                expected_ticks.push_back(want);
            end

            // compare each accepted result beat with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    mismatch_total++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("verdict", want.verdict, m_verdict);
                    check_field("interval_first", want.first, m_interval_first);
                    check_field("interval_second", want.second, m_interval_second);
                    check_field("interval_third", want.third, m_interval_third);
                    check_field("debounced_level", want.level, m_debounced_level);
                end
            end
        end
        fail_count      <= mismatch_total;
        pending         <= expected_ticks.size();
        trains_accepted <= accept_total;
        trains_refused  <= refuse_total;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the pulse train interval checker testbench: clock, reset, pin trains and bound writes.
// Depends on ptic_pkg, pulse_train_interval_checker and ptic_result_checker.
module testbench;
    import ptic_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_pin_level;
    logic                 m_valid;
    logic                 m_ready;
    logic [VERDICT_W-1:0] m_verdict;
    logic [TIMER_W-1:0]   m_interval_first;
    logic [TIMER_W-1:0]   m_interval_second;
    logic [TIMER_W-1:0]   m_interval_third;
    logic                 m_debounced_level;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [BOUND_W-1:0]   cfg_data;

    int   fail_count;
    int   pending;
    int   trains_accepted;
    int   trains_refused;

    logic pin_now       = 1'b0;
    logic quiet         = 1'b0;
    int   flip_pct      = 0;
    int   stall_left    = 0;
    int   beats_sent    = 0;
    int   settings_done = 0;

    always #1 aclk = ~aclk;

    pulse_train_interval_checker dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pin_level       (s_pin_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_verdict         (m_verdict),
        .m_interval_first  (m_interval_first),
        .m_interval_second (m_interval_second),
        .m_interval_third  (m_interval_third),
        .m_debounced_level (m_debounced_level),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    ptic_result_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pin_level       (s_pin_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_verdict         (m_verdict),
        .m_interval_first  (m_interval_first),
        .m_interval_second (m_interval_second),
        .m_interval_third  (m_interval_third),
        .m_debounced_level (m_debounced_level),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .pending           (pending),
        .trains_accepted   (trains_accepted),
        .trains_refused    (trains_refused)
    );

    // Mostly no gap, some short ones, a few long; none in a quiet stretch
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
        end
    end

    // Offer one pin sample and hold it until taken
    task automatic send_beat(input logic pin);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pin_level <= pin;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Hold a pin level, with occasional single-sample flips when noise is on
    task automatic hold_level(input logic lvl, input int len);
        for (int i = 0; i < len; i++)
            send_beat(($urandom_range(0, 99) < flip_pct) ? ~lvl : lvl);
    endtask

    task automatic toggle_run(input int len);
        pin_now = ~pin_now;
        hold_level(pin_now, len);
    endtask

    // Short excursion the debounce should swallow
    task automatic blip(input int len);
        hold_level(~pin_now, len);
    endtask

    // From an armed idle: restart edge, three judged intervals a, b, c, then a tail run
    task automatic send_train(input int a, input int b, input int c, input int tail);
        toggle_run(a);
        toggle_run(b);
        toggle_run(c);
        toggle_run(tail);
    endtask

    // Stop sending until every predicted result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_bounds(input int lo, input int hi);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MIN;
        cfg_data  <= lo[BOUND_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_MAX;
        cfg_data  <= hi[BOUND_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Run length, biased to straddle either bound
    function automatic int pick_len(input int lo, input int hi);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 30)      n = lo + $urandom_range(0, 2) - 1;
        else if (r < 60) n = hi + $urandom_range(0, 2) - 1;
        else             n = $urandom_range(5, 45);
        if (n < 5) n = 5;
        if (n > 480) n = 480;
        return n;
    endfunction

    task automatic random_phase(input int lo, input int hi);
        int start_beats;
        int start_trains;
        int trains_here;
        write_bounds(lo, hi);
        start_beats  = beats_sent;
        start_trains = trains_accepted + trains_refused;
        trains_here  = 0;
        while (beats_sent - start_beats < 100 ||
               trains_accepted + trains_refused - start_trains < 2) begin
            quiet    <= ($urandom_range(0, 9) == 0);
            flip_pct = ($urandom_range(0, 4) == 0) ? 3 : 0;
            if ($urandom_range(0, 19) == 0) blip($urandom_range(1, 4));
            send_train(pick_len(lo, hi), pick_len(lo, hi), pick_len(lo, hi),
                       pick_len(lo, hi));
            trains_here++;
            if (trains_here == 3) drain();
        end
        quiet    <= 1'b0;
        flip_pct = 0;
    endtask

    initial begin
        #6000000;
        $display("pulse_train_interval_checker test failed");
        $finish;
    end

    initial begin
        int lo;
        int hi;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_pin_level <= 1'b0;
        m_ready     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_MIN;
        cfg_data    <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset bounds; the first change after reset stores ticks since reset
        toggle_run(12);
        toggle_run(15);
        toggle_run(20);
        send_train(11, 29, 20, 9);
        send_train(10, 20, 30, 6);
        flip_pct = 4;
        blip(3);
        send_train(15, 18, 25, 7);
        flip_pct = 0;

        // Silence mid-train clears the buffer; the next change only restarts timing
        quiet <= 1'b1;
        toggle_run(15);
        toggle_run(15);
        hold_level(pin_now, 500);
        quiet <= 1'b0;
        send_train(12, 13, 14, 6);

        // Widest bounds, then crossed, equal and zero bounds
        write_bounds(0, 255);
        send_train(5, 6, 7, 5);
        write_bounds(255, 0);
        send_train(8, 8, 8, 5);
        write_bounds(20, 20);
        send_train(20, 21, 19, 5);
        write_bounds(0, 0);
        send_train(5, 6, 7, 5);

        // Random trains under the reset bounds and one random setting
        random_phase(MIN_RESET, MAX_RESET);
        lo = $urandom_range(0, 30);
        if ($urandom_range(0, 3) == 0) hi = $urandom_range(0, lo);
        else                           hi = lo + $urandom_range(2, 30);
        random_phase(lo, hi);

        drain();
        $display("Sent %0d pin beats across %0d bound settings: %0d trains accepted, %0d refused.",
                 beats_sent, settings_done, trains_accepted, trains_refused);
        if (fail_count == 0 && pending == 0) begin
            $display("pulse_train_interval_checker test passed");
        end else begin
            $display("pulse_train_interval_checker test failed");
        end
        $finish;
    end

endmodule

@@ pulse_train_interval_checker.f @@
design/ptic_pkg.sv
design/ptic_debounce.sv
design/pulse_train_interval_checker.sv
tb/ptic_result_checker.sv
tb/testbench.sv
